>>> sv/hcbp_pkg.sv
package hcbp_pkg;

  // Table geometry and code limits
  localparam int SYMBOL_COUNT = 264;
  localparam int MAX_CODE_LEN = 32;
  localparam int EOF_SYMBOL   = 258;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int SYM_W        = 9;
  localparam int KIND_W       = 2;
  localparam int BYTE_W       = 8;
  localparam int CNT_W        = 3;
  localparam int ADDR_W       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
  localparam bit EOF_PRESENT  = (EOF_SYMBOL < SYMBOL_COUNT);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_END    = 2'd2
  } hcbp_kind_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic write_entry;
    logic read_entry;
    logic read_eof;
    logic load_code;
    logic step;
    logic flush;
  } hcbp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic sym_in_range;
    logic len_zero;
    logic will_emit;
    logic out_free;
  } hcbp_stat_t;

endpackage

>>> sv/hcbp_if.sv
interface hcbp_in_if;
  import hcbp_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SYM_W-1:0]    symbol;
  logic [CODE_W-1:0]   code_bits;
  logic [LEN_W-1:0]    code_len;

  modport source (output valid, kind, symbol, code_bits, code_len, input ready);
  modport sink   (input valid, kind, symbol, code_bits, code_len, output ready);
endinterface

interface hcbp_out_if;
  import hcbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;
  logic              empty_res;

  modport source (output valid, out_byte, last, empty_res, input ready);
  modport sink   (input valid, out_byte, last, empty_res, output ready);
endinterface

>>> sv/hcbp_ctrl.sv
module hcbp_ctrl
  import hcbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [KIND_W-1:0] in_kind_i,
  output logic              in_ready_o,
  input  hcbp_stat_t        stat_i,
  output hcbp_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_PACK  = 4'b0100,
    ST_FLUSH = 4'b1000
  } hcbp_state_e;

  hcbp_state_e state_q, state_d;
  logic        end_q, end_d;
  logic        in_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    end_d   = end_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_kind_i)
            KIND_LOAD: begin
              cmd_o.write_entry = 1'b1;
            end
            KIND_ENCODE: begin
              if (stat_i.sym_in_range) begin
                cmd_o.read_entry = 1'b1;
                end_d            = 1'b0;
                state_d          = ST_READ;
              end
            end
            KIND_END: begin
              end_d = 1'b1;
              if (EOF_PRESENT) begin
                cmd_o.read_entry = 1'b1;
                cmd_o.read_eof   = 1'b1;
                state_d          = ST_READ;
              end else begin
                state_d = ST_FLUSH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        cmd_o.load_code = 1'b1;
        state_d         = ST_PACK;
      end
      ST_PACK: begin
        if (stat_i.len_zero) begin
          state_d = end_q ? ST_FLUSH : ST_IDLE;
        end else if (stat_i.will_emit) begin
          cmd_o.step = stat_i.out_free;
        end else begin
          // absorb the whole remainder into the pending byte
          cmd_o.step = 1'b1;
          state_d    = end_q ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      end_q   <= end_d;
    end
  end

endmodule

>>> sv/hcbp_dp.sv
module hcbp_dp
  import hcbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SYM_W-1:0]  in_symbol_i,
  input  logic [CODE_W-1:0] in_code_bits_i,
  input  logic [LEN_W-1:0]  in_code_len_i,
  input  hcbp_cmd_t         cmd_i,
  output hcbp_stat_t        stat_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_last_o,
  output logic              out_empty_o
);

  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } hcbp_entry_t;

  hcbp_entry_t       mem [SYMBOL_COUNT];
  hcbp_entry_t       rd_q;
  hcbp_entry_t       wr_entry;
  logic [ADDR_W-1:0] rd_addr;
  logic [LEN_W-1:0]  len_sat;

  logic [CODE_W-1:0] code_q;
  logic [LEN_W-1:0]  len_q;
  logic [BYTE_W-1:0] pend_q;
  logic [CNT_W-1:0]  pcnt_q;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;
  logic              out_empty_q;

  logic [2*BYTE_W-1:0] cat;
  logic [2*BYTE_W-1:0] emit_cat;
  logic [2*BYTE_W-1:0] absorb_cat;
  logic [2*BYTE_W-1:0] flush_cat;
  logic [3:0]          take_bits;
  logic [3:0]          absorb_shift;
  logic [LEN_W:0]      total;
  logic                will_emit;
  logic                out_free;

  // Saturate the loaded length and left-align the code
  assign len_sat = (in_code_len_i > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : in_code_len_i;
  assign wr_entry.len  = len_sat;
  assign wr_entry.bits = in_code_bits_i << (LEN_W'(CODE_W) - len_sat);

  assign rd_addr = cmd_i.read_eof ? ADDR_W'(EOF_SYMBOL) : in_symbol_i[ADDR_W-1:0];

  // Code table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_entry && stat_o.sym_in_range) begin
      mem[in_symbol_i[ADDR_W-1:0]] <= wr_entry;
    end
    if (cmd_i.read_entry) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Byte assembly from the pending bits and the top of the code
  assign cat          = {pend_q, code_q[CODE_W-1 -: BYTE_W]};
  assign total        = {{(LEN_W+1-CNT_W){1'b0}}, pcnt_q} + {1'b0, len_q};
  assign will_emit    = (total >= (LEN_W+1)'(BYTE_W));
  assign take_bits    = 4'd8 - {1'b0, pcnt_q};
  assign absorb_shift = 4'd8 - len_q[3:0];
  assign emit_cat     = cat >> pcnt_q;
  assign absorb_cat   = cat >> absorb_shift;
  assign flush_cat    = {pend_q, {BYTE_W{1'b0}}} >> pcnt_q;
  assign out_free     = !out_valid_q || out_ready_i;

  assign stat_o.sym_in_range = ({1'b0, in_symbol_i} < (SYM_W+1)'(SYMBOL_COUNT));
  assign stat_o.len_zero     = (len_q == '0);
  assign stat_o.will_emit    = will_emit;
  assign stat_o.out_free     = out_free;

  // Code shift register and pending byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
      len_q  <= '0;
      pend_q <= '0;
      pcnt_q <= '0;
    end else if (cmd_i.load_code) begin
      code_q <= rd_q.bits;
      len_q  <= rd_q.len;
    end else if (cmd_i.step) begin
      if (will_emit) begin
        code_q <= code_q << take_bits;
        len_q  <= len_q - {{(LEN_W-4){1'b0}}, take_bits};
        pend_q <= '0;
        pcnt_q <= '0;
      end else begin
        len_q  <= '0;
        pend_q <= absorb_cat[BYTE_W-1:0];
        pcnt_q <= total[CNT_W-1:0];
      end
    end else if (cmd_i.flush) begin
      pend_q <= '0;
      pcnt_q <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.step && will_emit) || cmd_i.flush) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && will_emit) begin
      out_byte_q  <= emit_cat[BYTE_W-1:0];
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
    end else if (cmd_i.flush) begin
      out_byte_q  <= flush_cat[BYTE_W-1:0];
      out_last_q  <= 1'b1;
      out_empty_q <= (pcnt_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_empty_o = out_empty_q;

endmodule

>>> sv/huffman_code_bit_packer_core.sv
// A load transaction writes its table entry when it is accepted; an encode passes
// through the registered table read, the code load and a packer that emits one byte
// per cycle while the sink is not stalled. An end transaction adds a flush step.
// Results leave through a one-entry output register; a stalled sink holds the packer.
// Reset (async, active low) clears the pending byte and controller; the code
// table is not cleared and must be loaded before use.
module huffman_code_bit_packer_core
  import hcbp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  hcbp_in_if.sink    in_i,
  hcbp_out_if.source out_o
);

  hcbp_cmd_t  cmd;
  hcbp_stat_t stat;

  // Sequencer
  hcbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Code table and bit packer
  hcbp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_symbol_i    (in_i.symbol),
    .in_code_bits_i (in_i.code_bits),
    .in_code_len_i  (in_i.code_len),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_byte_o     (out_o.out_byte),
    .out_last_o     (out_o.last),
    .out_empty_o    (out_o.empty_res)
  );

endmodule
